[rtl/ddw_pkg.sv]
// ----------------------------------------------------------------------------
// ddw_pkg
// shared types, field widths and digit codes for the decimal display writer
// ----------------------------------------------------------------------------
`default_nettype none

package ddw_pkg;

	localparam int DIGIT_POSITIONS_DEF = 8;
	localparam int QUEUE_DEPTH         = 2;

	localparam int VALUE_W  = 28;
	localparam int COUNT_W  = 4;
	localparam int POS_W    = 4;
	localparam int CODE_W   = 4;
	localparam int STATUS_W = 2;
	localparam int ITER_W   = $clog2(VALUE_W);

	localparam int S_DATA_W = 32;
	localparam int M_DATA_W = 16;

	localparam logic [CODE_W-1:0] CODE_MINUS = 4'd10;
	localparam logic [CODE_W-1:0] CODE_BLANK = 4'd15;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_WIDE  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_CONV,
		BK_EMIT
	} back_state_t;

	typedef struct packed {
		logic                err;
		logic                neg;
		logic [COUNT_W-1:0]  count;
		status_t             status;
		logic [VALUE_W-1:0]  mag;
	} ddw_item_t;

	function automatic logic [VALUE_W-1:0] pow10(input logic [COUNT_W-1:0] n);
		logic [VALUE_W-1:0] r;
		case (n)
			4'd0:    r = 28'd1;
			4'd1:    r = 28'd10;
			4'd2:    r = 28'd100;
			4'd3:    r = 28'd1000;
			4'd4:    r = 28'd10000;
			4'd5:    r = 28'd100000;
			4'd6:    r = 28'd1000000;
			4'd7:    r = 28'd10000000;
			4'd8:    r = 28'd100000000;
			default: r = 28'd100000000;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

[rtl/ddw_front.sv]
// ----------------------------------------------------------------------------
// ddw_front
// takes input items, works out sign, magnitude, range and width status
// ----------------------------------------------------------------------------
`default_nettype none

module ddw_front #(
	parameter int DIGIT_POSITIONS = ddw_pkg::DIGIT_POSITIONS_DEF
) (
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [ddw_pkg::S_DATA_W-1:0] s_tdata,
	output logic                              push_valid,
	input  wire logic                         push_ready,
	output ddw_pkg::ddw_item_t                push_item
);
	import ddw_pkg::*;

	logic [VALUE_W-1:0] raw;
	logic [COUNT_W-1:0] count;
	logic [COUNT_W-1:0] digits;
	logic               neg;
	logic [VALUE_W-1:0] mag;

	always_comb begin
		raw    = s_tdata[VALUE_W-1:0];
		count  = s_tdata[VALUE_W+COUNT_W-1:VALUE_W];
		mag    = raw[VALUE_W-1] ? (~raw + 28'd1) : raw;
		// sign needs a shown position of its own
		neg    = raw[VALUE_W-1] && (count != '0);
		digits = neg ? (count - 4'd1) : count;

		push_item.err    = count > COUNT_W'(DIGIT_POSITIONS);
		push_item.neg    = neg;
		push_item.count  = count;
		push_item.mag    = mag;
		push_item.status = (mag >= pow10(digits)) ? ST_WIDE : ST_OK;

		push_valid = s_tvalid;
		s_tready   = push_ready;
	end

endmodule

`default_nettype wire

[rtl/ddw_queue.sv]
// ----------------------------------------------------------------------------
// ddw_queue
// short item queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module ddw_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push_valid,
	output logic                    push_ready,
	input  wire ddw_pkg::ddw_item_t push_item,
	output logic                    pop_valid,
	input  wire logic               pop_ready,
	output ddw_pkg::ddw_item_t      pop_item
);
	import ddw_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	ddw_item_t        entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic             push;
	logic             pop;

	always_comb begin
		push_ready = fill_q != CNT_W'(QUEUE_DEPTH);
		pop_valid  = fill_q != '0;
		pop_item   = entry_q[rd_ptr_q];
		push       = push_valid && push_ready;
		pop        = pop_valid && pop_ready;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/ddw_back.sv]
// ----------------------------------------------------------------------------
// ddw_back
// bit-serial binary to bcd conversion and digit write sequencing
// ----------------------------------------------------------------------------
`default_nettype none

module ddw_back #(
	parameter int DIGIT_POSITIONS = ddw_pkg::DIGIT_POSITIONS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         pop_valid,
	output logic                              pop_ready,
	input  wire ddw_pkg::ddw_item_t           pop_item,
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic [ddw_pkg::M_DATA_W-1:0]      m_tdata,
	output logic                              m_tlast
);
	import ddw_pkg::*;

	localparam int BCD_W = 4 * DIGIT_POSITIONS;

	back_state_t         state_q, state_d;
	logic                err_q;
	logic                neg_q;
	logic [COUNT_W-1:0]  count_q;
	status_t             status_q;
	logic [VALUE_W-1:0]  mag_q;
	logic [BCD_W-1:0]    bcd_q;
	logic [ITER_W-1:0]   iter_q;
	logic [POS_W-1:0]    pos_q;

	logic                out_valid_q;
	logic [POS_W-1:0]    out_pos_q;
	logic [CODE_W-1:0]   out_code_q;
	status_t             out_status_q;
	logic                out_last_q;

	logic                emit_go;
	logic                load;
	logic [BCD_W-1:0]    bcd_adj;
	logic [CODE_W-1:0]   code_d;
	logic                last_d;

	always_comb begin
		for (int i = 0; i < DIGIT_POSITIONS; i++) begin
			bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? (bcd_q[4*i +: 4] + 4'd3)
			                                                : bcd_q[4*i +: 4];
		end
	end

	always_comb begin
		pop_ready = state_q == BK_IDLE;
		load      = pop_valid && pop_ready;
		emit_go   = (state_q == BK_EMIT) && (!out_valid_q || m_tready);
		last_d    = err_q || (pos_q == POS_W'(1));

		if (err_q || (pos_q > count_q)) begin
			code_d = CODE_BLANK;
		end else if (neg_q && (pos_q == count_q)) begin
			code_d = CODE_MINUS;
		end else begin
			code_d = bcd_q[BCD_W-1 -: 4];
		end

		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (load) begin
					state_d = pop_item.err ? BK_EMIT : BK_CONV;
				end
			end
			BK_CONV: begin
				if (iter_q == ITER_W'(VALUE_W - 1)) begin
					state_d = BK_EMIT;
				end
			end
			BK_EMIT: begin
				if (emit_go && last_d) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			err_q    <= pop_item.err;
			neg_q    <= pop_item.neg;
			count_q  <= pop_item.count;
			status_q <= pop_item.status;
			mag_q    <= pop_item.mag;
			bcd_q    <= '0;
			iter_q   <= '0;
			pos_q    <= POS_W'(DIGIT_POSITIONS);
		end else if (state_q == BK_CONV) begin
			bcd_q  <= {bcd_adj[BCD_W-2:0], mag_q[VALUE_W-1]};
			mag_q  <= mag_q << 1;
			iter_q <= iter_q + 1'b1;
		end else if (emit_go) begin
			bcd_q <= bcd_q << 4;
			pos_q <= pos_q - 1'b1;
		end
		if (emit_go) begin
			out_pos_q    <= err_q ? '0 : pos_q;
			out_code_q   <= code_d;
			out_status_q <= err_q ? ST_RANGE : status_q;
			out_last_q   <= last_d;
		end
	end

	always_comb begin
		m_tvalid = out_valid_q;
		m_tdata  = {6'd0, out_status_q, out_code_q, out_pos_q};
		m_tlast  = out_last_q;
	end

	a_conv_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_CONV) |-> !err_q)
		else $error("conversion running on a range error item");

	a_emit_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_EMIT && !err_q) |->
		(pos_q >= POS_W'(1)) && (pos_q <= POS_W'(DIGIT_POSITIONS)))
		else $error("digit position out of range while writing");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_go && last_d) |=> (state_q == BK_IDLE))
		else $error("sequencer kept writing after the final item");

	a_range_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q == ST_RANGE) |-> (out_last_q && out_pos_q == '0))
		else $error("range error item not single and final");

	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != BK_IDLE) |-> !pop_ready)
		else $error("queue popped while sequencer busy");

endmodule

`default_nettype wire

[rtl/decimal_digit_display_writer_top.sv]
// ----------------------------------------------------------------------------
// decimal_digit_display_writer_top
// flow: an item is registered in the queue, loaded by the back when it is idle,
// converted one bit a cycle, then written out through a registered output stage
// one digit write a cycle while the receiver does not stall; no new item is taken
// until the last write; a range error item skips conversion and gives one write
// reset: asynchronous, clears queue and sequencer, no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_digit_display_writer_top #(
	parameter int DIGIT_POSITIONS = ddw_pkg::DIGIT_POSITIONS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	// value [27:0], digit_count [31:28]
	input  wire logic [ddw_pkg::S_DATA_W-1:0] s_tdata,
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	// digit_position [3:0], digit_code [7:4], status [9:8], zero [15:10]
	output logic [ddw_pkg::M_DATA_W-1:0]      m_tdata,
	output logic                              m_tlast
);
	import ddw_pkg::*;

	logic      push_valid;
	logic      push_ready;
	ddw_item_t push_item;
	logic      pop_valid;
	logic      pop_ready;
	ddw_item_t pop_item;

	ddw_front #(
		.DIGIT_POSITIONS(DIGIT_POSITIONS)
	) u_front (
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	ddw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	ddw_back #(
		.DIGIT_POSITIONS(DIGIT_POSITIONS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

`default_nettype wire

[test/decimal_digit_display_writer_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_digit_display_writer_top_test
// self-checking bench: each accepted value is turned into its expected digit
// writes by a local predictor and every write leaving the block is compared
// field by field, under random bursts, receiver stalls and a long hold-off
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_digit_display_writer_top_test;
	import ddw_pkg::*;

	localparam int POSITIONS = DIGIT_POSITIONS_DEF;
	localparam logic [POS_W-1:0] ERROR_POSITION = '0;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 80;
	localparam int MAX_REPORTS = 20;

	localparam int CODE_LO = POS_W;
	localparam int STATUS_LO = POS_W + CODE_W;
	localparam int PAD_LO = POS_W + CODE_W + STATUS_W;

	typedef struct packed {
		logic [POS_W-1:0]  position;
		logic [CODE_W-1:0] code;
		status_t           status;
		logic              last;
	} digit_write_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	logic [M_DATA_W-1:0] m_tdata;
	logic                m_tlast;

	digit_write_t awaited_writes[$];
	int errors;
	int items_sent;
	int writes_seen;
	int range_items;
	int wide_items;
	int burst_left;
	bit hold_req;

	decimal_digit_display_writer_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#4ms;
		$display("timeout with %0d digit writes still outstanding", awaited_writes.size());
		$display("== FAIL ==");
		$finish;
	end

	function automatic longint unsigned ten_to(input int n);
		longint unsigned p;
		p = 1;
		repeat (n) p = p * 10;
		return p;
	endfunction

	// digit writes for one value, position 8 down to 1, or one position 0 write on a range error
	function automatic void predict_writes(input logic [VALUE_W-1:0] value,
			input logic [COUNT_W-1:0] count);
		logic               neg;
		logic [VALUE_W-1:0] mag;
		int                 shown;
		status_t            st;
		digit_write_t       w;
		neg = value[VALUE_W-1];
		mag = neg ? (~value + 1'b1) : value;
		if (count > POSITIONS) begin
			w.position = ERROR_POSITION;
			w.code = CODE_BLANK;
			w.status = ST_RANGE;
			w.last = 1'b1;
			awaited_writes.push_back(w);
			range_items++;
			return;
		end
		// no room for the minus sign
		if (count == 0)
			neg = 1'b0;
		shown = neg ? count - 1 : count;
		st = (mag >= ten_to(shown)) ? ST_WIDE : ST_OK;
		if (st == ST_WIDE)
			wide_items++;
		for (int p = POSITIONS; p >= 1; p--) begin
			w.position = POS_W'(p);
			w.status = st;
			w.last = (p == 1);
			if (p > count)
				w.code = CODE_BLANK;
			else if (neg && p == count)
				w.code = CODE_MINUS;
			else
				w.code = CODE_W'((mag / ten_to(p - 1)) % 10);
			awaited_writes.push_back(w);
		end
	endfunction

	task automatic report_mismatch(input string field, input logic [31:0] want,
			input logic [31:0] got);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("mismatch at %0t on write %0d: %s expected %0d got %0d",
				$time, writes_seen, field, want, got);
	endtask

	always @(posedge clk) begin : check_writes
		digit_write_t w;
		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			writes_seen++;
			if (awaited_writes.size() == 0) begin
				report_mismatch("unexpected write, tdata", 32'(0), 32'(m_tdata));
			end else begin
				w = awaited_writes.pop_front();
				if (m_tdata[POS_W-1:0] !== w.position)
					report_mismatch("digit_position", 32'(w.position),
						32'(m_tdata[POS_W-1:0]));
				if (m_tdata[CODE_LO +: CODE_W] !== w.code)
					report_mismatch("digit_code", 32'(w.code),
						32'(m_tdata[CODE_LO +: CODE_W]));
				if (m_tdata[STATUS_LO +: STATUS_W] !== w.status)
					report_mismatch("status", 32'(w.status),
						32'(m_tdata[STATUS_LO +: STATUS_W]));
				if (m_tdata[M_DATA_W-1:PAD_LO] !== '0)
					report_mismatch("padding", 32'(0), 32'(m_tdata[M_DATA_W-1:PAD_LO]));
				if (m_tlast !== w.last)
					report_mismatch("last", 32'(w.last), 32'(m_tlast));
			end
		end
	end

	// receiver: free runs, stall streaks, single-cycle noise, one long hold-off
	initial begin : receiver
		int free_left;
		int stall_left;
		int r;
		m_tready = 1'b0;
		free_left = 0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else if (free_left > 0) begin
				m_tready <= 1'b1;
				free_left--;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				r = $urandom_range(0, 9);
				if (r < 2)
					free_left = $urandom_range(10, 60);
				else if (r == 2)
					stall_left = $urandom_range(2, 10);
				m_tready <= ($urandom_range(0, 2) != 0);
			end
		end
	end

	task automatic send_value(input int value, input int count);
		if (burst_left == 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat ($urandom_range(0, 11)) @(negedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
				: $urandom_range(1, 6);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {COUNT_W'(count), VALUE_W'(value)};
		burst_left--;
		do @(posedge clk); while (s_tready !== 1'b1);
		predict_writes(VALUE_W'(value), COUNT_W'(count));
		items_sent++;
	endtask

	task automatic send_random();
		int                 r;
		int                 count;
		int                 shown;
		int                 len;
		bit                 neg;
		logic [VALUE_W-1:0] mag;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			send_value($urandom, $urandom_range(POSITIONS + 1, 15));
		end else if (r < 3) begin
			send_value($urandom, $urandom_range(0, POSITIONS));
		end else begin
			// well-formed: magnitude fits the shown digits
			count = $urandom_range(0, POSITIONS);
			neg = (count > 0) && $urandom_range(0, 1);
			shown = neg ? count - 1 : count;
			len = $urandom_range(0, shown);
			mag = VALUE_W'($urandom_range(0, int'(ten_to(len) - 1)));
			send_value(neg ? int'(~mag + 1'b1) : int'(mag), count);
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (awaited_writes.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed();
		send_value(0, 0);
		send_value(0, 1);
		send_value(0, POSITIONS);
		send_value(7, 1);
		send_value(99999999, 8);
		send_value(-99999999, 8);
		send_value(-9999999, 8);
		send_value(12345678, 8);
		send_value(-1234567, 8);
		send_value(12345678, 4);
		send_value(-5, 2);
		send_value(-5, 1);
		send_value(-42, 0);
		send_value(134217727, 8);
		send_value(-134217728, 8);
		send_value(-134217728, 0);
		send_value(99999999, 9);
		send_value(0, 15);
		send_value(-1, 12);
		send_value(9, 3);
		send_value(100, 3);
		send_value(1000, 3);
		send_value(-99, 3);
		send_value(-100, 3);
	endtask

	task automatic test_random(input int n);
		repeat (n) send_random();
	endtask

	task automatic test_backpressure();
		hold_req = 1'b1;
		repeat (14) send_random();
		wait_drained();
	endtask

	task automatic test_pause();
		repeat (20) send_random();
		wait_drained();
		repeat (20) send_random();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		hold_req = 1'b0;
		errors = 0;
		items_sent = 0;
		writes_seen = 0;
		range_items = 0;
		wide_items = 0;
		burst_left = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random(230);
		test_backpressure();
		test_pause();

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("sent %0d values, checked %0d digit writes (%0d count errors, %0d too wide)",
			items_sent, writes_seen, range_items, wide_items);
		$display("random bursts and stalls, one %0d-cycle receiver hold-off, one full drain",
			HOLD_CYCLES);
		if (errors == 0 && awaited_writes.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire
